// File: sv/elfr_pkg.sv
// Shared types and codes for the escaped length frame receiver.
package elfr_pkg;

    localparam logic [7:0] FRAME_DELIM = 8'h7E;
    localparam logic [7:0] ESCAPE_BYTE = 8'h7D;
    localparam logic [7:0] ESCAPE_XOR  = 8'h20;
    localparam logic [7:0] SUM_TARGET  = 8'hFF;
    localparam logic [15:0] LIMIT_RESET = 16'd124;

    // link modes
    localparam logic [1:0] MODE_HUNT  = 2'd0;
    localparam logic [1:0] MODE_FRAME = 2'd1;
    localparam logic [1:0] MODE_ESC   = 2'd2;
    localparam logic [1:0] MODE_SKIP  = 2'd3;

    // frame phases
    localparam logic [1:0] PH_LEN_HI = 2'd0;
    localparam logic [1:0] PH_LEN_LO = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_CSUM   = 2'd3;

    // status codes
    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_BADLEN  = 3'd2;
    localparam logic [2:0] ST_BADSUM  = 3'd3;
    localparam logic [2:0] ST_RESTART = 3'd4;
    localparam logic [2:0] ST_JUNK    = 3'd5;

    // register map
    localparam int unsigned ADDR_W = 2;
    localparam logic [ADDR_W-1:0] ADDR_BUFFER_BYTES = 2'd0;

    typedef struct packed {
        logic [2:0]  status;
        logic        data_valid;
        logic [7:0]  data_byte;
        logic [15:0] data_index;
        logic [15:0] frame_length;
    } t_result;

endpackage

// File: sv/elfr_cfg.sv
// Configuration register file with an APB-style slave port.
module elfr_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [elfr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [15:0]                 o_buffer_bytes
);
    import elfr_pkg::*;

    logic [15:0] r_buffer_bytes;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_BUFFER_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_bytes <= LIMIT_RESET;
        end else if (wr_en) begin
            r_buffer_bytes <= pwdata[15:0];
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_BUFFER_BYTES: prdata = {16'd0, r_buffer_bytes};
            default:           prdata = 32'd0;
        endcase
    end

    assign o_buffer_bytes = r_buffer_bytes;

endmodule

// File: sv/elfr_parse.sv
// Byte parser: input register, frame state update and result register.
module elfr_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [15:0]       i_buffer_bytes,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output elfr_pkg::t_result o_result
);
    import elfr_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_result     r_out;

    logic [1:0]  r_mode, n_mode;
    logic [1:0]  r_phase, n_phase;
    logic [15:0] r_dlen, n_dlen;
    logic [15:0] r_cnt, n_cnt;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_limit, n_limit;

    logic        out_free;
    logic        fire;
    logic        take;
    logic [7:0]  fb;
    logic [15:0] len;
    logic [15:0] cnt_inc;
    logic [7:0]  sum_inc;
    t_result     res;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Per-byte state update
    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_dlen  = r_dlen;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_limit = r_limit;
        res     = '0;
        take    = 1'b0;
        fb      = r_in_byte;

        unique case (r_mode)
            MODE_HUNT: begin
                if (r_in_byte == FRAME_DELIM) begin
                    n_mode  = MODE_FRAME;
                    n_phase = PH_LEN_HI;
                    n_limit = i_buffer_bytes;
                end else begin
                    if (r_in_byte == ESCAPE_BYTE) begin
                        n_mode = MODE_SKIP;
                    end
                    res.status = ST_JUNK;
                end
            end
            MODE_FRAME: begin
                if (r_in_byte == FRAME_DELIM) begin
                    n_phase    = PH_LEN_HI;
                    n_limit    = i_buffer_bytes;
                    res.status = ST_RESTART;
                end else if (r_in_byte == ESCAPE_BYTE) begin
                    n_mode = MODE_ESC;
                end else begin
                    take = 1'b1;
                end
            end
            MODE_ESC: begin
                n_mode = MODE_FRAME;
                fb     = r_in_byte ^ ESCAPE_XOR;
                take   = 1'b1;
            end
            default: begin
                n_mode = MODE_HUNT;
            end
        endcase

        len     = {r_dlen[15:8], fb};
        cnt_inc = r_cnt + 16'd1;
        sum_inc = r_sum + fb;

        if (take) begin
            unique case (r_phase)
                PH_LEN_HI: begin
                    n_dlen  = {fb, 8'h00};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_dlen = len;
                    if (len == 16'd0 || len >= r_limit) begin
                        n_phase    = PH_LEN_HI;
                        n_mode     = MODE_HUNT;
                        res.status = ST_BADLEN;
                    end else begin
                        n_sum   = 8'd0;
                        n_cnt   = 16'd0;
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    res.data_valid = 1'b1;
                    res.data_byte  = fb;
                    res.data_index = r_cnt;
                    n_sum          = sum_inc;
                    n_cnt          = cnt_inc;
                    if (cnt_inc >= r_dlen) begin
                        n_phase = PH_CSUM;
                    end
                end
                default: begin
                    n_mode  = MODE_HUNT;
                    n_phase = PH_LEN_HI;
                    if (sum_inc == SUM_TARGET) begin
                        res.status       = ST_OK;
                        res.frame_length = r_dlen;
                    end else begin
                        res.status = ST_BADSUM;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_HUNT;
            r_phase <= PH_LEN_HI;
            r_dlen  <= 16'd0;
            r_cnt   <= 16'd0;
            r_sum   <= 8'd0;
            r_limit <= LIMIT_RESET;
        end else if (fire) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_dlen  <= n_dlen;
            r_cnt   <= n_cnt;
            r_sum   <= n_sum;
            r_limit <= n_limit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

`ifndef SYNTHESIS
    a_data_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.data_valid |-> r_out.status == ST_PENDING)
        else $error("payload byte reported with a non-pending status");

    a_len_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.frame_length != 16'd0 |-> r_out.status == ST_OK)
        else $error("frame length reported without frame ok");

    a_index_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.data_valid |-> r_out.data_index < r_limit)
        else $error("payload index beyond latched buffer size");

    a_count_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_cnt < r_dlen)
        else $error("payload count reached declared length in data phase");

    a_skip_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_mode == MODE_SKIP |=> r_mode == MODE_HUNT)
        else $error("skip mode lasted longer than one byte");
`endif

endmodule

// File: sv/escaped_length_frame_receiver.sv
// Top level: escaped, length-prefixed frame receiver with 8-bit checksum.
// A byte passes the input register, then the result register. Throughput:
// one byte per cycle unless the output stalls; the frame state update is a
// single registered pass, and the result register decouples the two channels.
// Reset (synchronous, active low): hunting for delimiter, buffer size 124,
// no transactions in flight.
module escaped_length_frame_receiver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [elfr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [2:0]                  o_status,
    output logic                        o_data_valid,
    output logic [7:0]                  o_data_byte,
    output logic [15:0]                 o_data_index,
    output logic [15:0]                 o_frame_length
);
    import elfr_pkg::*;

    logic [15:0] buffer_bytes;
    t_result     result;

    elfr_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_buffer_bytes (buffer_bytes)
    );

    elfr_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_buffer_bytes (buffer_bytes),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result       (result)
    );

    assign o_status       = result.status;
    assign o_data_valid   = result.data_valid;
    assign o_data_byte    = result.data_byte;
    assign o_data_index   = result.data_index;
    assign o_frame_length = result.frame_length;

endmodule
